[sv/blri_pkg.sv]
// Shared types and constants for the bounded list insert and readout block.
`default_nettype none

package blri_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned POS_W = 5;
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_READ   = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_BAD_POS = 3'd2,
    STAT_EMPTY   = 3'd3,
    STAT_ELEM    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_NEW,
    CELL_LEFT,
    CELL_RIGHT,
    CELL_FIRST
  } cell_op_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [POS_W-1:0]   position;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] element;
    logic               last;
  } out_t;

endpackage

`default_nettype wire

[sv/blri_cell.sv]
// One list cell: holds a single entry and loads from a neighbour or the new value.
`default_nettype none

module blri_cell (
  input  wire                     clk_i,
  input  blri_pkg::cell_op_e      op_i,
  input  wire logic signed [31:0] new_i,
  input  wire logic signed [31:0] left_i,
  input  wire logic signed [31:0] right_i,
  input  wire logic signed [31:0] first_i,
  output logic signed [31:0]      data_o
);

  logic signed [31:0] data_q;
  logic signed [31:0] data_d;

  always_comb begin
    case (op_i)
      blri_pkg::CELL_NEW:   data_d = new_i;
      blri_pkg::CELL_LEFT:  data_d = left_i;
      blri_pkg::CELL_RIGHT: data_d = right_i;
      blri_pkg::CELL_FIRST: data_d = first_i;
      default:              data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

[sv/bounded_list_insert_readout.sv]
// Top level: bounded ordered list built as a chain of entry cells.
// Append or insert: the status result is registered in the cycle after the input transfer;
//   the next item may be taken in the following cycle (one cycle per item when unstalled).
// Readout of N entries: the read state is entered after the transfer, then the results follow
//   one per cycle while the output is not stalled, set by the single ring rotation through the
//   cells; input is held off until the last result is registered. Reset clears the entry count,
//   the sequencer and the output valid; cell contents are undefined until written and never read before then.
`default_nettype none

module bounded_list_insert_readout (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  blri_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output blri_pkg::out_t out_data_o
);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  state_e                         state_q;
  logic [blri_pkg::CNT_W-1:0]     count_q;
  logic [blri_pkg::CNT_W-1:0]     rd_left_q;
  logic                           out_valid_q;
  blri_pkg::out_t                 out_q;

  logic                           out_free;
  logic                           in_xfer;
  logic                           is_update;
  logic                           list_full;
  logic                           bad_pos;
  logic                           do_write;
  logic                           rd_step;
  logic [blri_pkg::CMP_W-1:0]     cnt_ext;
  logic [blri_pkg::CMP_W-1:0]     pos_ext;
  logic [blri_pkg::CMP_W-1:0]     tgt;
  blri_pkg::status_e              upd_status;

  logic signed [31:0]             cell_data [blri_pkg::DEPTH];
  blri_pkg::cell_op_e             cell_op   [blri_pkg::DEPTH];

  // The output register may load when empty or when its result leaves this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign cnt_ext = blri_pkg::CMP_W'(count_q);
  assign pos_ext = blri_pkg::CMP_W'(in_data_i.position);

  assign is_update = (in_data_i.func == blri_pkg::FUNC_APPEND) ||
                     (in_data_i.func == blri_pkg::FUNC_INSERT);
  assign list_full = (count_q == blri_pkg::CNT_W'(blri_pkg::DEPTH));
  // Only an insert can carry a bad position; an append always lands at the tail.
  assign bad_pos   = (in_data_i.func == blri_pkg::FUNC_INSERT) && (pos_ext > cnt_ext);
  assign do_write  = in_xfer && is_update && !list_full && !bad_pos;
  assign tgt       = (in_data_i.func == blri_pkg::FUNC_APPEND) ? cnt_ext : pos_ext;

  // Full is checked before the position.
  always_comb begin
    if (list_full) begin
      upd_status = blri_pkg::STAT_FULL;
    end else if (bad_pos) begin
      upd_status = blri_pkg::STAT_BAD_POS;
    end else begin
      upd_status = blri_pkg::STAT_OK;
    end
  end

  assign rd_step = (state_q == ST_READ) && out_free;

  // Cell chain. An insert opens a gap at the target by moving the entries from there
  // up to the tail one cell to the right. A readout step rotates the occupied cells
  // one place towards cell 0, so after count steps the list is back in order.
  for (genvar i = 0; i < blri_pkg::DEPTH; i++) begin : g_cell
    localparam logic [blri_pkg::CMP_W-1:0] CellIdx  = blri_pkg::CMP_W'(i);
    localparam logic [blri_pkg::CMP_W-1:0] CellNext = blri_pkg::CMP_W'(i + 1);

    logic signed [31:0] left_data;
    logic signed [31:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = in_data_i.value;
    end else begin : g_mid
      assign left_data = cell_data[i-1];
    end

    if (i == blri_pkg::DEPTH - 1) begin : g_end
      assign right_data = cell_data[0];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    always_comb begin
      cell_op[i] = blri_pkg::CELL_HOLD;
      if (do_write) begin
        if (CellIdx == tgt) begin
          cell_op[i] = blri_pkg::CELL_NEW;
        end else if ((CellIdx > tgt) && (CellIdx <= cnt_ext)) begin
          cell_op[i] = blri_pkg::CELL_LEFT;
        end
      end else if (rd_step) begin
        if (CellNext < cnt_ext) begin
          cell_op[i] = blri_pkg::CELL_RIGHT;
        end else if (CellNext == cnt_ext) begin
          cell_op[i] = blri_pkg::CELL_FIRST;
        end
      end
    end

    blri_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[i]),
      .new_i   (in_data_i.value),
      .left_i  (left_data),
      .right_i (right_data),
      .first_i (cell_data[0]),
      .data_o  (cell_data[i])
    );
  end

  // Sequencer, entry count and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_left_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Drop the held result once it has been transferred.
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (is_update) begin
              out_valid_q   <= 1'b1;
              out_q.status  <= upd_status;
              out_q.element <= '0;
              out_q.last    <= 1'b1;
              if (do_write) begin
                count_q <= count_q + blri_pkg::CNT_W'(1);
              end
            end else if (in_data_i.func == blri_pkg::FUNC_READ) begin
              if (count_q == '0) begin
                out_valid_q   <= 1'b1;
                out_q.status  <= blri_pkg::STAT_EMPTY;
                out_q.element <= '0;
                out_q.last    <= 1'b1;
              end else begin
                state_q   <= ST_READ;
                rd_left_q <= count_q;
              end
            end
          end
        end
        ST_READ: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_q.status  <= blri_pkg::STAT_ELEM;
            out_q.element <= cell_data[0];
            out_q.last    <= (rd_left_q == blri_pkg::CNT_W'(1));
            rd_left_q     <= rd_left_q - blri_pkg::CNT_W'(1);
            if (rd_left_q == blri_pkg::CNT_W'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[sv/blri_checker.sv]
// Port-level checks for the bounded list block, bound to the top level.
`default_nettype none

module blri_checker (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            in_valid_i,
  input wire            in_stall_o,
  input blri_pkg::in_t  in_data_i,
  input wire            out_valid_o,
  input wire            out_stall_i,
  input blri_pkg::out_t out_data_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Status results carry a zero element and close the item.
  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != blri_pkg::STAT_ELEM)
    |-> (out_data_o.element == 32'sd0) && out_data_o.last)
    else $error("status result with element or without last");

  // An append or insert answers with its status in the next cycle.
  a_update_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    ((in_data_i.func == blri_pkg::FUNC_APPEND) || (in_data_i.func == blri_pkg::FUNC_INSERT))
    |=> out_valid_o && out_data_o.last && (out_data_o.status != blri_pkg::STAT_ELEM))
    else $error("update without status result");

  // No new item is taken while a readout is still in progress.
  a_read_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == blri_pkg::STAT_ELEM) && !out_data_o.last
    |-> in_stall_o)
    else $error("input taken during readout");

endmodule

bind bounded_list_insert_readout blri_checker u_blri_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the bounded list insert and readout block.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CLK_HALF     = 6;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDLE_PERCENT = 13;
  localparam int unsigned FULL_ITEMS   = 150;
  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  blri_pkg::in_t  in_data = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  blri_pkg::out_t out_data;

  // Random idling on both sides; cleared for the quiet stretch.
  bit          idle_enable = 1'b1;
  logic        hold_req    = 1'b0;
  int unsigned hold_left;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  // Shadow copy of the list and the results still owed by the block.
  logic signed [31:0] model_entries [blri_pkg::DEPTH];
  int unsigned        model_count = 0;
  blri_pkg::out_t     expected_results [$];

  bounded_list_insert_readout uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Abort the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL bounded_list_insert_readout");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off for a long stretch on request so
  // that the block backs up and stalls its input.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= idle_enable && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Compare every output transfer with the oldest outstanding expectation.
  always @(posedge clk) begin : check_results
    blri_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d element %0d last %0d",
               out_data.status, out_data.element, out_data.last);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_data.status);
          error_count++;
        end
        if (out_data.element !== want.element) begin
          $error("element mismatch: expected %0d, actual %0d",
                 want.element, out_data.element);
          error_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, out_data.last);
          error_count++;
        end
      end
    end
  end

  function automatic blri_pkg::out_t status_result(input blri_pkg::status_e code);
    blri_pkg::out_t res;
    res.status  = code;
    res.element = '0;
    res.last    = 1'b1;
    return res;
  endfunction

  // Update the shadow list for one accepted item and queue the results it owes.
  task automatic apply_list_op(input blri_pkg::in_t item);
    int unsigned    idx;
    blri_pkg::out_t res;
    case (item.func)
      blri_pkg::FUNC_APPEND: begin
        if (model_count >= blri_pkg::DEPTH) begin
          expected_results.push_back(status_result(blri_pkg::STAT_FULL));
        end else begin
          model_entries[model_count] = item.value;
          model_count++;
          expected_results.push_back(status_result(blri_pkg::STAT_OK));
        end
      end
      blri_pkg::FUNC_INSERT: begin
        // Fullness wins over a bad position.
        if (model_count >= blri_pkg::DEPTH) begin
          expected_results.push_back(status_result(blri_pkg::STAT_FULL));
        end else if (item.position > model_count) begin
          expected_results.push_back(status_result(blri_pkg::STAT_BAD_POS));
        end else begin
          for (idx = model_count; idx > item.position; idx--) begin
            model_entries[idx] = model_entries[idx - 1];
          end
          model_entries[item.position] = item.value;
          model_count++;
          expected_results.push_back(status_result(blri_pkg::STAT_OK));
        end
      end
      blri_pkg::FUNC_READ: begin
        if (model_count == 0) begin
          expected_results.push_back(status_result(blri_pkg::STAT_EMPTY));
        end else begin
          for (idx = 0; idx < model_count; idx++) begin
            res.status  = blri_pkg::STAT_ELEM;
            res.element = model_entries[idx];
            res.last    = (idx + 1 == model_count);
            expected_results.push_back(res);
          end
        end
      end
      default: begin
        // Unused code: dropped without any result.
      end
    endcase
  endtask

  function automatic blri_pkg::in_t make_item(input logic [1:0] func, input int unsigned pos,
                                              input logic signed [31:0] value);
    blri_pkg::in_t item;
    item.func     = func;
    item.position = pos[blri_pkg::POS_W-1:0];
    item.value    = value;
    return item;
  endfunction

  // Offer one item, hold it until the transfer, then predict its results.
  // Valid stays high between back-to-back items.
  task automatic send_item(input blri_pkg::in_t item);
    if (idle_enable && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_list_op(item);
  endtask

  // Status paths on an empty and a short list, plus front, middle and tail inserts.
  task automatic test_short_list;
    send_item(make_item(blri_pkg::FUNC_READ, 0, 32'sd0));
    send_item(make_item(blri_pkg::FUNC_INSERT, 1, -32'sd1));
    send_item(make_item(blri_pkg::FUNC_INSERT, 31, VAL_MAX));
    send_item(make_item(FUNC_UNUSED, 31, VAL_MIN));
    send_item(make_item(blri_pkg::FUNC_INSERT, 0, VAL_MIN));
    send_item(make_item(blri_pkg::FUNC_APPEND, 0, VAL_MAX));
    send_item(make_item(blri_pkg::FUNC_INSERT, 1, 32'sd0));
    send_item(make_item(blri_pkg::FUNC_INSERT, 4, 32'sh2aaa_aaaa));
    send_item(make_item(blri_pkg::FUNC_INSERT, 3, 32'sh5555_5555));
    send_item(make_item(blri_pkg::FUNC_READ, 0, 32'sd0));
  endtask

  // Grow the list with random content until it is full, reading it back on the way.
  task automatic test_random_fill;
    int unsigned pick;
    int unsigned pos;
    while (model_count < blri_pkg::DEPTH) begin
      pick = $urandom_range(99);
      pos  = ($urandom_range(99) < 75) ? $urandom_range(model_count) : $urandom_range(31);
      if (pick < 5) begin
        send_item(make_item(FUNC_UNUSED, $urandom_range(31), $urandom));
      end else if (pick < 25) begin
        send_item(make_item(blri_pkg::FUNC_READ, $urandom_range(31), $urandom));
      end else if (pick < 55) begin
        send_item(make_item(blri_pkg::FUNC_APPEND, $urandom_range(31), $urandom));
      end else begin
        send_item(make_item(blri_pkg::FUNC_INSERT, pos, $urandom));
      end
    end
  endtask

  // Full list: both updates refused, even with a bad position, then a full readout.
  task automatic test_full_list;
    send_item(make_item(blri_pkg::FUNC_APPEND, 0, VAL_MIN));
    send_item(make_item(blri_pkg::FUNC_INSERT, 0, VAL_MAX));
    send_item(make_item(blri_pkg::FUNC_INSERT, blri_pkg::DEPTH, 32'sd1));
    send_item(make_item(blri_pkg::FUNC_INSERT, 31, -32'sd1));
    send_item(make_item(blri_pkg::FUNC_READ, 0, 32'sd0));
  endtask

  // Random traffic on the full list, with a quiet stretch in the middle.
  task automatic test_random_traffic;
    int unsigned counted;
    int unsigned pick;
    counted = 0;
    while (counted < FULL_ITEMS) begin
      idle_enable = !(counted >= 60 && counted < 120);
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_item(make_item(FUNC_UNUSED, $urandom_range(31), $urandom));
      end else begin
        if (pick < 50) begin
          send_item(make_item(blri_pkg::FUNC_READ, $urandom_range(31), $urandom));
        end else if (pick < 75) begin
          send_item(make_item(blri_pkg::FUNC_APPEND, $urandom_range(31), $urandom));
        end else begin
          send_item(make_item(blri_pkg::FUNC_INSERT, $urandom_range(31), $urandom));
        end
        counted++;
      end
    end
    idle_enable = 1'b1;
  endtask

  // Hold the receiver off while readouts keep coming, so the input backs up.
  task automatic test_output_hold;
    in_valid <= 1'b0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (6) send_item(make_item(blri_pkg::FUNC_READ, 0, 32'sd0));
    send_item(make_item(blri_pkg::FUNC_APPEND, 0, 32'sd7));
  endtask

  // Let every owed result arrive, then allow a readout's worth of extra cycles.
  task automatic wait_drain;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (blri_pkg::DEPTH + 4) @(posedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_list;
    test_random_fill;
    test_full_list;
    test_random_traffic;
    test_output_hold;

    in_valid <= 1'b0;
    wait_drain;
    if (error_count == 0) begin
      $display("PASS bounded_list_insert_readout");
    end else begin
      $display("FAIL bounded_list_insert_readout");
    end
    $finish;
  end

endmodule
